@@ rtl/core/edc_pkg.sv @@
// Shared types and constants for the exposure derivative compensation unit.
// Holds the register map, reset values and the configuration struct.
// No dependencies.
`default_nettype none

package edc_pkg;

	// Default counter saturation value and the register index width
	localparam int EDC_MAX_PIXELS = 65536;
	localparam int REG_IDX_W      = 3;
	localparam int REG_DATA_W     = 31;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_OVER_LEVEL      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_UNDER_LEVEL     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_OVER_FRACTION   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_UNDER_FRACTION  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_OVER_FLOOR      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_OVER_GAIN       = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_UNDER_FLOOR     = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_UNDER_GAIN      = 3'd7;

	// Configuration register file
	typedef struct packed {
		logic [7:0]  over_level;
		logic [7:0]  under_level;
		logic [15:0] over_enable_fraction;
		logic [15:0] under_enable_fraction;
		logic [30:0] over_floor;
		logic [15:0] over_gain;
		logic [30:0] under_floor;
		logic [15:0] under_gain;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		over_level:            8'd250,
		under_level:           8'd5,
		over_enable_fraction:  16'd6554,
		under_enable_fraction: 16'd6554,
		over_floor:            31'd65536,
		over_gain:             16'd256,
		under_floor:           31'd65536,
		under_gain:            16'd256
	};

endpackage

`default_nettype wire

@@ rtl/core/edc_scale.sv @@
// One compensation class: clamp magnitude up to the floor, scale by a Q8.8 gain,
// truncate and saturate to the positive 31-bit range. Uses edc_pkg.
`default_nettype none

module edc_scale
	import edc_pkg::*;
(
	input  wire logic [31:0] mag,
	input  wire logic [30:0] floor_val,
	input  wire logic [15:0] gain,
	output logic      [30:0] result
);

	logic [31:0] clamped;
	logic [47:0] prod;
	logic [39:0] shifted;

	// Floor clamp, Q8.8 x Q16.16 product, drop 8 fraction bits, saturate
	always_comb begin
		clamped = (mag < {1'b0, floor_val}) ? {1'b0, floor_val} : mag;
		prod    = 48'(gain) * 48'(clamped);
		shifted = prod[47:8];
		result  = (|shifted[39:31]) ? {31{1'b1}} : shifted[30:0];
	end

endmodule

`default_nettype wire

@@ rtl/core/edc_stats.sv @@
// Statistics pass counters and the latched compensation enables.
// Uses edc_pkg for the configuration struct.
`default_nettype none

module edc_stats
	import edc_pkg::*;
#(
	parameter int MAX_PIXELS = EDC_MAX_PIXELS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic stat_item,
	input  wire logic last,
	input  wire logic is_over,
	input  wire logic is_under,
	input  wire cfg_t cfg,
	output logic      over_enabled,
	output logic      under_enabled
);

	localparam int CNT_W = $clog2(MAX_PIXELS + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PIXELS);

	logic [CNT_W-1:0]    over_count_q, under_count_q, pixel_count_q;
	logic [CNT_W-1:0]    over_nxt, under_nxt, pixel_nxt;
	logic [CNT_W+15:0]   over_prod, under_prod;
	logic                over_hit, under_hit;
	logic                over_enabled_q, under_enabled_q;

	// Saturating counts including the current item
	always_comb begin
		pixel_nxt = (pixel_count_q < MAX_CNT) ? pixel_count_q + 1'b1 : pixel_count_q;
		over_nxt  = over_count_q;
		under_nxt = under_count_q;
		if (is_over) begin
			over_nxt = (over_count_q < MAX_CNT) ? over_count_q + 1'b1 : over_count_q;
		end else if (is_under) begin
			under_nxt = (under_count_q < MAX_CNT) ? under_count_q + 1'b1 : under_count_q;
		end
	end

	// Fraction test: count * 2^16 strictly above fraction * total
	always_comb begin
		over_prod  = (CNT_W+16)'(cfg.over_enable_fraction) * (CNT_W+16)'(pixel_nxt);
		under_prod = (CNT_W+16)'(cfg.under_enable_fraction) * (CNT_W+16)'(pixel_nxt);
		over_hit   = {over_nxt, 16'd0} > over_prod;
		under_hit  = {under_nxt, 16'd0} > under_prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_count_q    <= '0;
			under_count_q   <= '0;
			pixel_count_q   <= '0;
			over_enabled_q  <= 1'b0;
			under_enabled_q <= 1'b0;
		end else if (stat_item) begin
			if (last) begin
				over_enabled_q  <= over_hit;
				under_enabled_q <= under_hit;
				over_count_q    <= '0;
				under_count_q   <= '0;
				pixel_count_q   <= '0;
			end else begin
				over_count_q  <= over_nxt;
				under_count_q <= under_nxt;
				pixel_count_q <= pixel_nxt;
			end
		end
	end

	assign over_enabled  = over_enabled_q;
	assign under_enabled = under_enabled_q;

	// Class counts never pass the pixel count, which never passes the limit
	a_over_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		over_count_q <= pixel_count_q) else $error("over count above pixel count");
	a_under_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		under_count_q <= pixel_count_q) else $error("under count above pixel count");
	a_total_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_count_q <= MAX_CNT) else $error("pixel count above limit");

endmodule

`default_nettype wire

@@ rtl/core/exposure_deriv_compensation_unit.sv @@
// Exposure derivative compensation unit, top level.
// Path: a compensation item passes the stage 1, stage 2 and stage 3 registers to the output.
// Throughput: one item per cycle while out_stall is low; the over and under multipliers sit in separate stages.
// Statistics items update counters at acceptance and produce no result.
// Reset clears counters, enables and pipeline valids; registers take their defaults.
// Uses edc_pkg, edc_stats and edc_scale.
`default_nettype none

module exposure_deriv_compensation_unit
	import edc_pkg::*;
#(
	parameter int MAX_PIXELS = EDC_MAX_PIXELS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write port
	input  wire logic                  wr_en,
	input  wire logic [REG_IDX_W-1:0]  wr_index,
	input  wire logic [REG_DATA_W-1:0] wr_data,
	// input channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  cmd,
	input  wire logic [7:0]            intensity,
	input  wire logic signed [31:0]    deriv_in,
	input  wire logic                  frame_end,
	// output channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [31:0]         deriv_out,
	output logic                       over_applied,
	output logic                       under_applied,
	output logic                       pass_end
);

	cfg_t cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_OVER_LEVEL:     cfg_q.over_level            <= wr_data[7:0];
				REG_UNDER_LEVEL:    cfg_q.under_level           <= wr_data[7:0];
				REG_OVER_FRACTION:  cfg_q.over_enable_fraction  <= wr_data[15:0];
				REG_UNDER_FRACTION: cfg_q.under_enable_fraction <= wr_data[15:0];
				REG_OVER_FLOOR:     cfg_q.over_floor            <= wr_data[30:0];
				REG_OVER_GAIN:      cfg_q.over_gain             <= wr_data[15:0];
				REG_UNDER_FLOOR:    cfg_q.under_floor           <= wr_data[30:0];
				REG_UNDER_GAIN:     cfg_q.under_gain            <= wr_data[15:0];
				default: ;
			endcase
		end
	end

	// Handshake: each stage moves when it is empty or the next one moves
	logic valid_s1, valid_s2, valid_s3;
	logic rdy1, rdy2, rdy3;
	logic accept;

	assign rdy3     = !valid_s3 || !out_stall;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_stall = !rdy1;
	assign accept   = in_valid && rdy1;

	// Pixel classification
	logic is_over, is_under;
	logic over_enabled, under_enabled;

	assign is_over  = intensity >= cfg_q.over_level;
	assign is_under = intensity <= cfg_q.under_level;

	edc_stats #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_stats (
		.clk          (clk),
		.arst_n       (arst_n),
		.stat_item    (accept && !cmd),
		.last         (frame_end),
		.is_over      (is_over),
		.is_under     (is_under),
		.cfg          (cfg_q),
		.over_enabled (over_enabled),
		.under_enabled(under_enabled)
	);

	// Stage 1: input register, enables sampled with the item
	logic [31:0] deriv_s1;
	logic        do_over_s1, do_under_s1, last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy1) begin
			valid_s1 <= in_valid && cmd;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			deriv_s1    <= deriv_in;
			do_over_s1  <= over_enabled && is_over;
			do_under_s1 <= under_enabled && is_under;
			last_s1     <= frame_end;
		end
	end

	// Over compensation on the two's complement magnitude
	logic [31:0] mag_s1;
	logic [30:0] over_res;

	assign mag_s1 = deriv_s1[31] ? (~deriv_s1 + 32'd1) : deriv_s1;

	edc_scale u_over (
		.mag      (mag_s1),
		.floor_val(cfg_q.over_floor),
		.gain     (cfg_q.over_gain),
		.result   (over_res)
	);

	// Stage 2
	logic [31:0] mag_s2, res_s2;
	logic        over_s2, do_under_s2, last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			mag_s2      <= do_over_s1 ? {1'b0, over_res} : mag_s1;
			res_s2      <= do_over_s1 ? {1'b0, over_res} : deriv_s1;
			over_s2     <= do_over_s1;
			do_under_s2 <= do_under_s1;
			last_s2     <= last_s1;
		end
	end

	// Under compensation works on the over result, or on the magnitude when over is not applied
	logic [30:0] under_res;

	edc_scale u_under (
		.mag      (mag_s2),
		.floor_val(cfg_q.under_floor),
		.gain     (cfg_q.under_gain),
		.result   (under_res)
	);

	// Stage 3: result register
	logic [31:0] res_s3;
	logic        over_s3, under_s3, last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			res_s3   <= do_under_s2 ? {1'b0, under_res} : res_s2;
			over_s3  <= over_s2;
			under_s3 <= do_under_s2;
			last_s3  <= last_s2;
		end
	end

	assign out_valid     = valid_s3;
	assign deriv_out     = res_s3;
	assign over_applied  = over_s3;
	assign under_applied = under_s3;
	assign pass_end      = last_s3;

	// A compensated result is a saturated magnitude, never negative
	a_over_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && over_s3 |-> !res_s3[31]) else $error("over result negative");
	a_under_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && under_s3 |-> !res_s3[31]) else $error("under result negative");
	// A stage holding an item that cannot move keeps it
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !rdy3 |=> valid_s2 && $stable(res_s2)) else $error("stage 2 item lost");

endmodule

`default_nettype wire
